>>> rtl/core/bdc_pkg.sv
// Shared types, constants and calendar helper functions for the business day counter.
`default_nettype none

package bdc_pkg;

  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 14;
  localparam int WD_W       = 3;
  localparam int CNT_W      = 22;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam int YEAR_MAX   = 9999;
  localparam int MONTHS     = 12;

  // Constant-divisor unit.
  localparam int DIV_D_W    = 9;
  localparam int DIV_Q_W    = 12;
  localparam int DIV_SH_W   = DIV_D_W + DIV_Q_W;
  localparam int DIV_LEAP   = 400;
  localparam int DIV_WEEK   = 7;

  // Reciprocals: floor(x * RECIP >> SH) equals floor(x / divisor) for every 14-bit x.
  localparam int RECIP_W       = 15;
  localparam int PROD_W        = YEAR_W + RECIP_W;
  localparam int RECIP_LEAP    = 5243;
  localparam int RECIP_LEAP_SH = 21;
  localparam int RECIP_WEEK    = 18725;
  localparam int RECIP_WEEK_SH = 17;

  localparam int REM_W      = 9;
  localparam int QUOT_W     = 6;
  localparam int CENT_W     = 8;
  localparam int SUM_W      = 15;

  localparam logic [REM_W-1:0] LEAP_CYCLE_LAST = REM_W'(DIV_LEAP - 1);

  localparam logic [WD_W-1:0] FRIDAY   = 3'd5;
  localparam logic [WD_W-1:0] SATURDAY = 3'd6;
  localparam logic [WD_W-1:0] SUNDAY   = 3'd0;

  typedef enum logic {
    DIV_BY_LEAP,
    DIV_BY_WEEK
  } div_mode_t;

  typedef struct packed {
    logic      load;
    logic      sel_end;
    logic      div_go;
    div_mode_t div_mode;
    logic      cap_year;
    logic      cap_wday;
    logic      walk_init;
    logic      walk_step;
    logic      out_load;
  } bdc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic walk_more;
  } bdc_status_t;

  // Days in a month; zero for a month code outside one to twelve.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // floor(31 * mm / 12) for the shifted month number mm (March is one).
  function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] mm);
    logic [DAY_W-1:0] off;
    unique case (mm)
      4'd1:    off = 5'd2;
      4'd2:    off = 5'd5;
      4'd3:    off = 5'd7;
      4'd4:    off = 5'd10;
      4'd5:    off = 5'd12;
      4'd6:    off = 5'd15;
      4'd7:    off = 5'd18;
      4'd8:    off = 5'd20;
      4'd9:    off = 5'd23;
      4'd10:   off = 5'd25;
      4'd11:   off = 5'd28;
      4'd12:   off = 5'd31;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // Whole centuries inside a year remainder modulo 400.
  function automatic logic [1:0] century_part(input logic [REM_W-1:0] r);
    logic [1:0] c;
    if (r >= 9'd300) begin
      c = 2'd3;
    end else if (r >= 9'd200) begin
      c = 2'd2;
    end else if (r >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

  function automatic logic is_century(input logic [REM_W-1:0] r);
    return (r == 9'd0) || (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
  endfunction

  // Leap test from the two low year bits and the year modulo 400.
  function automatic logic is_leap(input logic [1:0] y_low, input logic [REM_W-1:0] r);
    return ((y_low == 2'b00) && !is_century(r)) || (r == 9'd0);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bdc_cdiv.sv
// Shared divider by a constant of 400 or 7: reciprocal multiply for the quotient, then the remainder.
`default_nettype none

module bdc_cdiv (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire bdc_pkg::div_mode_t            mode,
  input  wire logic [bdc_pkg::YEAR_W-1:0]    operand,
  output logic                               busy,
  output logic [bdc_pkg::DIV_Q_W-1:0]        quot,
  output logic [bdc_pkg::YEAR_W-1:0]         rem
);

  logic [bdc_pkg::RECIP_W-1:0]  recip;
  logic [bdc_pkg::PROD_W-1:0]   prod;
  logic [bdc_pkg::DIV_Q_W-1:0]  quot_next;
  logic [bdc_pkg::DIV_D_W-1:0]  divisor;
  logic [bdc_pkg::YEAR_W-1:0]   dividend;
  logic [bdc_pkg::DIV_SH_W-1:0] back;

  assign recip = (mode == bdc_pkg::DIV_BY_WEEK) ? bdc_pkg::RECIP_W'(bdc_pkg::RECIP_WEEK)
                                                : bdc_pkg::RECIP_W'(bdc_pkg::RECIP_LEAP);
  assign prod  = bdc_pkg::PROD_W'(operand) * bdc_pkg::PROD_W'(recip);

  assign quot_next = (mode == bdc_pkg::DIV_BY_WEEK)
                   ? bdc_pkg::DIV_Q_W'(prod >> bdc_pkg::RECIP_WEEK_SH)
                   : bdc_pkg::DIV_Q_W'(prod >> bdc_pkg::RECIP_LEAP_SH);

  // Quotient times divisor never exceeds the dividend, so it fits the year width.
  assign back = bdc_pkg::DIV_SH_W'(quot) * bdc_pkg::DIV_SH_W'(divisor);

  // The remainder is registered in the cycle after the quotient, while busy is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dividend <= operand;
      quot     <= quot_next;
      if (mode == bdc_pkg::DIV_BY_WEEK) begin
        divisor <= bdc_pkg::DIV_D_W'(bdc_pkg::DIV_WEEK);
      end else begin
        divisor <= bdc_pkg::DIV_D_W'(bdc_pkg::DIV_LEAP);
      end
    end
    if (busy) begin
      rem <= dividend - back[bdc_pkg::YEAR_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bdc_datapath.sv
// Datapath: date registers, validity and weekday arithmetic, the day walk and the result registers.
`default_nettype none

module bdc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bdc_pkg::bdc_cmd_t           cmd,
  output bdc_pkg::bdc_status_t             status,
  input  wire logic [bdc_pkg::DAY_W-1:0]   start_day,
  input  wire logic [bdc_pkg::MON_W-1:0]   start_month,
  input  wire logic [bdc_pkg::YEAR_W-1:0]  start_year,
  input  wire logic [bdc_pkg::DAY_W-1:0]   end_day,
  input  wire logic [bdc_pkg::MON_W-1:0]   end_month,
  input  wire logic [bdc_pkg::YEAR_W-1:0]  end_year,
  output logic [bdc_pkg::CNT_W-1:0]        business_days,
  output logic [bdc_pkg::WD_W-1:0]         start_weekday,
  output logic [bdc_pkg::WD_W-1:0]         end_weekday,
  output logic                             date_invalid
);

  // Captured request.
  logic [bdc_pkg::DAY_W-1:0]  sd, ed;
  logic [bdc_pkg::MON_W-1:0]  sm, em;
  logic [bdc_pkg::YEAR_W-1:0] sy, ey;

  // Per-date results.
  logic                       valid_s, valid_e;
  logic [bdc_pkg::REM_W-1:0]  r_s;
  logic [bdc_pkg::WD_W-1:0]   sw, ew;
  logic [bdc_pkg::YEAR_W-1:0] wsum;

  // Walk state.
  logic [bdc_pkg::DAY_W-1:0]  walk_day;
  logic [bdc_pkg::MON_W-1:0]  walk_month;
  logic [bdc_pkg::YEAR_W-1:0] walk_year;
  logic [bdc_pkg::WD_W-1:0]   walk_weekday;
  logic [bdc_pkg::REM_W-1:0]  walk_r400;
  logic [bdc_pkg::CNT_W-1:0]  day_tally;

  // Divider.
  logic                        div_busy;
  logic [bdc_pkg::DIV_Q_W-1:0] div_quot;
  logic [bdc_pkg::YEAR_W-1:0]  div_rem;
  logic [bdc_pkg::YEAR_W-1:0]  div_operand;

  // Arithmetic on the selected date.
  logic [bdc_pkg::DAY_W-1:0]  cur_d;
  logic [bdc_pkg::MON_W-1:0]  cur_m;
  logic [bdc_pkg::YEAR_W-1:0] cur_y;
  logic [bdc_pkg::REM_W-1:0]  r;
  logic [bdc_pkg::QUOT_W-1:0] q;
  logic                       cur_leap;
  logic                       cur_valid;
  logic                       jan_feb;
  logic                       borrow;
  logic [bdc_pkg::REM_W-1:0]  ryy;
  logic [bdc_pkg::QUOT_W-1:0] qyy;
  logic [bdc_pkg::YEAR_W-1:0] yy;
  logic [bdc_pkg::CENT_W-1:0] cyy;
  logic [bdc_pkg::MON_W-1:0]  mm;
  logic [bdc_pkg::SUM_W-1:0]  sum_full;

  // Walk helpers.
  logic                       walk_leap;
  logic                       month_end;
  logic                       at_end;
  logic                       start_before_end;
  logic                       walk_ok;

  assign div_operand = (cmd.div_mode == bdc_pkg::DIV_BY_WEEK) ? wsum : cur_y;

  bdc_cdiv u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (cmd.div_go),
    .mode    (cmd.div_mode),
    .operand (div_operand),
    .busy    (div_busy),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  assign cur_d = cmd.sel_end ? ed : sd;
  assign cur_m = cmd.sel_end ? em : sm;
  assign cur_y = cmd.sel_end ? ey : sy;

  assign r        = div_rem[bdc_pkg::REM_W-1:0];
  assign q        = div_quot[bdc_pkg::QUOT_W-1:0];
  assign cur_leap = bdc_pkg::is_leap(cur_y[1:0], r);

  assign cur_valid = (cur_y != '0) && (cur_y <= bdc_pkg::YEAR_W'(bdc_pkg::YEAR_MAX)) &&
                     (cur_m != '0) && (cur_m <= bdc_pkg::MON_W'(bdc_pkg::MONTHS)) &&
                     (cur_d != '0) && (cur_d <= bdc_pkg::month_len(cur_m, cur_leap));

  // January and February count as months of the previous year.
  assign jan_feb = cur_m <= 4'd2;
  assign borrow  = jan_feb && (r == '0);
  assign ryy     = borrow ? bdc_pkg::LEAP_CYCLE_LAST : r - bdc_pkg::REM_W'(jan_feb);
  assign qyy     = q - bdc_pkg::QUOT_W'(borrow);
  assign yy      = cur_y - bdc_pkg::YEAR_W'(jan_feb);
  assign cyy     = {qyy, 2'b00} + bdc_pkg::CENT_W'(bdc_pkg::century_part(ryy));
  assign mm      = jan_feb ? cur_m + 4'd10 : cur_m - 4'd2;

  assign sum_full = bdc_pkg::SUM_W'(cur_d) + bdc_pkg::SUM_W'(yy) + bdc_pkg::SUM_W'(yy >> 2)
                  - bdc_pkg::SUM_W'(cyy) + bdc_pkg::SUM_W'(qyy)
                  + bdc_pkg::SUM_W'(bdc_pkg::month_offset(mm));

  assign walk_leap = bdc_pkg::is_leap(walk_year[1:0], walk_r400);
  assign month_end = walk_day == bdc_pkg::month_len(walk_month, walk_leap);
  assign at_end    = (walk_day == ed) && (walk_month == em) && (walk_year == ey);

  assign start_before_end = {sy, sm, sd} < {ey, em, ed};
  assign walk_ok          = valid_s && valid_e && start_before_end;

  assign status.div_busy  = div_busy;
  assign status.walk_more = walk_ok && !at_end;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sd <= start_day;
      sm <= start_month;
      sy <= start_year;
      ed <= end_day;
      em <= end_month;
      ey <= end_year;
    end

    if (cmd.cap_year) begin
      wsum <= sum_full[bdc_pkg::YEAR_W-1:0];
      if (cmd.sel_end) begin
        valid_e <= cur_valid;
      end else begin
        valid_s <= cur_valid;
        r_s     <= r;
      end
    end

    if (cmd.cap_wday) begin
      if (cmd.sel_end) begin
        ew <= valid_e ? div_rem[bdc_pkg::WD_W-1:0] : bdc_pkg::SUNDAY;
      end else begin
        sw <= valid_s ? div_rem[bdc_pkg::WD_W-1:0] : bdc_pkg::SUNDAY;
      end
    end

    if (cmd.walk_init) begin
      walk_day     <= sd;
      walk_month   <= sm;
      walk_year    <= sy;
      walk_weekday <= (valid_s && valid_e) ? sw : bdc_pkg::SUNDAY;
      walk_r400    <= r_s;
      day_tally    <= '0;
    end else if (cmd.walk_step) begin
      if ((walk_weekday != bdc_pkg::FRIDAY) && (walk_weekday != bdc_pkg::SATURDAY)) begin
        day_tally <= day_tally + 1'b1;
      end
      walk_weekday <= (walk_weekday == bdc_pkg::SATURDAY) ? bdc_pkg::SUNDAY
                                                          : walk_weekday + 1'b1;
      if (month_end) begin
        walk_day <= bdc_pkg::DAY_W'(1);
        if (walk_month == bdc_pkg::MON_W'(bdc_pkg::MONTHS)) begin
          walk_month <= bdc_pkg::MON_W'(1);
          walk_year  <= walk_year + 1'b1;
          walk_r400  <= (walk_r400 == bdc_pkg::LEAP_CYCLE_LAST) ? '0 : walk_r400 + 1'b1;
        end else begin
          walk_month <= walk_month + 1'b1;
        end
      end else begin
        walk_day <= walk_day + 1'b1;
      end
    end

    if (cmd.out_load) begin
      business_days <= day_tally;
      start_weekday <= sw;
      end_weekday   <= ew;
      date_invalid  <= !(valid_s && valid_e);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bdc_ctrl.sv
// Controller state machine that sequences the date checks, the day walk and the result handshake.
`default_nettype none

module bdc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_valid,
  output logic                       s_ready,
  output logic                       m_valid,
  input  wire logic                  m_ready,
  input  wire bdc_pkg::bdc_status_t  status,
  output bdc_pkg::bdc_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YGO,
    ST_YWAIT,
    ST_WGO,
    ST_WWAIT,
    ST_WINIT,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state;
  logic   sel_end;

  assign s_ready = state == ST_IDLE;

  always_comb begin
    cmd          = '0;
    cmd.sel_end  = sel_end;
    cmd.div_mode = bdc_pkg::DIV_BY_LEAP;
    unique case (state)
      ST_IDLE:  cmd.load      = s_valid;
      ST_YGO:   cmd.div_go    = 1'b1;
      ST_YWAIT: cmd.cap_year  = !status.div_busy;
      ST_WGO: begin
        cmd.div_go   = 1'b1;
        cmd.div_mode = bdc_pkg::DIV_BY_WEEK;
      end
      ST_WWAIT: cmd.cap_wday  = !status.div_busy;
      ST_WINIT: cmd.walk_init = 1'b1;
      ST_WALK:  cmd.walk_step = status.walk_more;
      ST_DONE:  cmd.out_load  = !m_valid || m_ready;
      default:  cmd.load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sel_end <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_valid) begin
            state   <= ST_YGO;
            sel_end <= 1'b0;
          end
        end
        ST_YGO:   state <= ST_YWAIT;
        ST_YWAIT: begin
          if (!status.div_busy) begin
            state <= ST_WGO;
          end
        end
        ST_WGO:   state <= ST_WWAIT;
        ST_WWAIT: begin
          if (!status.div_busy) begin
            if (sel_end) begin
              state <= ST_WINIT;
            end else begin
              sel_end <= 1'b1;
              state   <= ST_YGO;
            end
          end
        end
        ST_WINIT: state <= ST_WALK;
        ST_WALK: begin
          if (!status.walk_more) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/business_day_counter.sv
// The result follows the input transfer after the divider passes and a walk over the span
// in days when both dates are valid and start precedes end; otherwise there is no walk.
// One day is stepped per cycle. Per date, a shared constant divider makes one pass for
// the year modulo 400 and one for the weekday modulo 7. One item at a time; the next
// transfer is taken the cycle after the result is registered. Synchronous active-high
// reset returns the controller to idle.
`default_nettype none

module business_day_counter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request stream.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // From bit 0: start_day[4:0], start_month[3:0], start_year[13:0],
  // end_day[4:0], end_month[3:0], end_year[13:0], two zero bits.
  input  wire logic [bdc_pkg::IN_DATA_W-1:0]     s_tdata,
  // Result stream.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // From bit 0: business_days[21:0], start_weekday[2:0], end_weekday[2:0], four zero bits.
  output logic [bdc_pkg::OUT_DATA_W-1:0]         m_tdata,
  // Single field: date_invalid.
  output logic                                   m_tuser
);

  bdc_pkg::bdc_cmd_t    cmd;
  bdc_pkg::bdc_status_t status;

  logic [bdc_pkg::CNT_W-1:0] business_days;
  logic [bdc_pkg::WD_W-1:0]  start_weekday;
  logic [bdc_pkg::WD_W-1:0]  end_weekday;

  // The controller owns the handshakes; the datapath only sees commands.
  bdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // The request fields are captured on the transfer and held for the whole computation.
  bdc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .start_day     (s_tdata[4:0]),
    .start_month   (s_tdata[8:5]),
    .start_year    (s_tdata[22:9]),
    .end_day       (s_tdata[27:23]),
    .end_month     (s_tdata[31:28]),
    .end_year      (s_tdata[45:32]),
    .business_days (business_days),
    .start_weekday (start_weekday),
    .end_weekday   (end_weekday),
    .date_invalid  (m_tuser)
  );

  // The result registers hold steady while the downstream side stalls.
  assign m_tdata = {4'b0000, end_weekday, start_weekday, business_days};

endmodule

`default_nettype wire

>>> rtl/core/bdc_checker.sv
// Port-level checker for the business day counter and its bind to the top level.
`default_nettype none

module bdc_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [bdc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  wire logic                             m_tuser
);

  // Only one request is in flight: after a transfer the input side closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again right after a transfer");

  // An invalid date always reports a zero count.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[21:0] == 22'd0))
    else $error("nonzero count with an invalid date");

  // Weekdays are in range and the padding bits stay clear.
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[24:22] != 3'd7) && (m_tdata[27:25] != 3'd7) &&
                  (m_tdata[31:28] == 4'd0)))
    else $error("weekday out of range or padding set");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind business_day_counter bdc_checker u_bdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/tb_business_day_counter.sv
`timescale 1ns / 100ps
// Self-checking testbench for the business day counter: directed and random date pairs.
module tb_business_day_counter;

  // One calendar date as it sits in the request word: day lowest, then month, then year.
  typedef struct packed {
    logic [bdc_pkg::YEAR_W-1:0] year;
    logic [bdc_pkg::MON_W-1:0]  month;
    logic [bdc_pkg::DAY_W-1:0]  day;
  } cal_date_t;

  // A request: the start date in the low bits, the end date above it.
  typedef struct packed {
    cal_date_t end_date;
    cal_date_t start_date;
  } date_pair_t;

  // The answer that the block owes for one request.
  typedef struct {
    logic [bdc_pkg::CNT_W-1:0] business_days;
    logic [bdc_pkg::WD_W-1:0]  start_weekday;
    logic [bdc_pkg::WD_W-1:0]  end_weekday;
    logic                      date_invalid;
  } day_tally_t;

  localparam int unsigned RANDOM_REQUESTS = 1525;
  localparam int unsigned MAX_RANDOM_WALK = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam int unsigned TAIL_CYCLES     = 64;
  localparam int unsigned MAX_PRINTED     = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // From bit 0: start_day, start_month, start_year, end_day, end_month, end_year, zero fill.
  logic [bdc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // From bit 0: business_days, start_weekday, end_weekday, zero fill.
  logic [bdc_pkg::OUT_DATA_W-1:0] m_tdata;
  // Single field: date_invalid.
  logic                           m_tuser;

  // Requests waiting to be offered, and answers waiting for their result transfer.
  date_pair_t date_pair_queue[$];
  day_tally_t tally_queue[$];

  // The predictor's copy of the block state: where the last walk stopped and its count.
  cal_date_t                 walk_stop;
  logic [bdc_pkg::WD_W-1:0]  walk_stop_weekday;
  logic [bdc_pkg::CNT_W-1:0] last_count;

  date_pair_t  on_bus;
  day_tally_t  oldest;
  logic        hold_off = 1'b0;
  int unsigned gap_left, calm_tx, roll_tx;
  int unsigned stall_left, calm_rx, roll_rx;
  int unsigned error_count, requests_sent, results_checked, invalid_seen, longest_walk;

  always #5 clk = ~clk;

  business_day_counter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------------------
  // Calendar arithmetic of the predictor. Days are numbered from 0001-01-01 as day one, which
  // was a Monday, so the day number modulo seven is the weekday with Sunday as zero.
  // ---------------------------------------------------------------------------------------
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // A month outside one to twelve has no days, so the day test rejects it as well.
  function automatic bit date_ok(cal_date_t c);
    return (c.year >= 1) && (c.year <= bdc_pkg::YEAR_MAX) && (c.day >= 1) &&
           (c.day <= month_days(c.year, c.month));
  endfunction

  function automatic int unsigned day_serial(cal_date_t c);
    int unsigned p, n, k;
    p = c.year - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (k = 1; k < c.month; k++) begin
      n += month_days(c.year, k);
    end
    return n + c.day;
  endfunction

  // Works out the answer for one accepted request and moves the predictor's state along.
  function automatic day_tally_t predict_tally(date_pair_t q);
    day_tally_t  t;
    bit          sv, ev;
    int unsigned s_ser, e_ser, span, cnt, wd, k;
    sv    = date_ok(q.start_date);
    ev    = date_ok(q.end_date);
    s_ser = sv ? day_serial(q.start_date) : 0;
    e_ser = ev ? day_serial(q.end_date) : 0;
    t.start_weekday = sv ? bdc_pkg::WD_W'(s_ser % 7) : bdc_pkg::SUNDAY;
    t.end_weekday   = ev ? bdc_pkg::WD_W'(e_ser % 7) : bdc_pkg::SUNDAY;
    cnt = 0;
    if (sv && ev && (s_ser < e_ser)) begin
      // Every full week holds five counted days; the leftover days are checked one by one.
      span = e_ser - s_ser;
      cnt  = (span / 7) * 5;
      for (k = 0; k < span % 7; k++) begin
        wd = (t.start_weekday + k) % 7;
        if ((wd != bdc_pkg::FRIDAY) && (wd != bdc_pkg::SATURDAY)) begin
          cnt++;
        end
      end
      if (span > longest_walk) begin
        longest_walk = span;
      end
      walk_stop         = q.end_date;
      walk_stop_weekday = t.end_weekday;
    end else begin
      // No walk: the block stays at the start date, without a weekday if a date is bad.
      walk_stop         = q.start_date;
      walk_stop_weekday = (sv && ev) ? t.start_weekday : bdc_pkg::SUNDAY;
    end
    t.business_days = bdc_pkg::CNT_W'(cnt);
    t.date_invalid  = !(sv && ev);
    last_count      = t.business_days;
    return t;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  function automatic date_pair_t date_pair(int unsigned sd, int unsigned sm, int unsigned sy,
                                           int unsigned ed, int unsigned em, int unsigned ey);
    date_pair_t q;
    q.start_date.day   = bdc_pkg::DAY_W'(sd);
    q.start_date.month = bdc_pkg::MON_W'(sm);
    q.start_date.year  = bdc_pkg::YEAR_W'(sy);
    q.end_date.day     = bdc_pkg::DAY_W'(ed);
    q.end_date.month   = bdc_pkg::MON_W'(em);
    q.end_date.year    = bdc_pkg::YEAR_W'(ey);
    return q;
  endfunction

  // Steps a date forward; past 9999-12-31 it runs into year 10000, which is a bad date.
  function automatic cal_date_t date_after(cal_date_t c, int unsigned n);
    cal_date_t   r;
    int unsigned d, m, y, i;
    d = c.day;
    m = c.month;
    y = c.year;
    for (i = 0; i < n; i++) begin
      d++;
      if (d > month_days(y, m)) begin
        d = 1;
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
    end
    r.day   = bdc_pkg::DAY_W'(d);
    r.month = bdc_pkg::MON_W'(m);
    r.year  = bdc_pkg::YEAR_W'(y);
    return r;
  endfunction

  // A valid date, leaning toward century years, the ends of the year range and February.
  function automatic cal_date_t rand_date();
    cal_date_t   c;
    int unsigned y, m, len;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 11))
          0:       y = 1;
          1:       y = 2;
          2:       y = 4;
          3:       y = 100;
          4:       y = 400;
          5:       y = 1600;
          6:       y = 1700;
          7:       y = 1800;
          8:       y = 1900;
          9:       y = 2000;
          10:      y = 2100;
          default: y = 9999;
        endcase
      end
      1:       y = $urandom_range(9990, 9999);
      default: y = $urandom_range(1, bdc_pkg::YEAR_MAX);
    endcase
    m   = ($urandom_range(0, 6) == 0) ? 2 : $urandom_range(1, bdc_pkg::MONTHS);
    len = month_days(y, m);
    c.year  = bdc_pkg::YEAR_W'(y);
    c.month = bdc_pkg::MON_W'(m);
    if ($urandom_range(0, 4) == 0) begin
      c.day = bdc_pkg::DAY_W'($urandom_range(0, 1) ? len : 1);
    end else begin
      c.day = bdc_pkg::DAY_W'($urandom_range(1, len));
    end
    return c;
  endfunction

  // Breaks one field of a valid date so that the date is certainly invalid.
  function automatic cal_date_t corrupt_date(cal_date_t c);
    int unsigned len;
    len = month_days(c.year, c.month);
    case ($urandom_range(0, 5))
      0:       c.day   = '0;
      1:       c.day   = (len < 31) ? bdc_pkg::DAY_W'(len + 1) : '0;
      2:       c.month = '0;
      3:       c.month = bdc_pkg::MON_W'($urandom_range(13, 15));
      4:       c.year  = '0;
      default: c.year  = bdc_pkg::YEAR_W'($urandom_range(bdc_pkg::YEAR_MAX + 1, 16383));
    endcase
    return c;
  endfunction

  // Any bit pattern at all, valid or not.
  function automatic cal_date_t raw_date();
    cal_date_t c;
    c.day   = bdc_pkg::DAY_W'($urandom_range(0, 31));
    c.month = bdc_pkg::MON_W'($urandom_range(0, 15));
    c.year  = bdc_pkg::YEAR_W'($urandom_range(0, 16383));
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Request driver. A request stays on the bus until its transfer; after each transfer a
  // random gap may follow, mostly short, now and then long, and in calm stretches none.
  // The answer is predicted at the edge where the transfer happens.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      gap_left  <= 0;
      calm_tx   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        tally_queue.push_back(predict_tally(on_bus));
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (date_pair_queue.size() != 0) begin
          on_bus   = date_pair_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= bdc_pkg::IN_DATA_W'(on_bus);
          if (calm_tx != 0) begin
            gap_left <= 0;
            calm_tx  <= calm_tx - 1;
          end else begin
            roll_tx = $urandom_range(0, 99);
            if (roll_tx < 3) begin
              calm_tx  <= 30;
              gap_left <= 0;
            end else if (roll_tx < 45) begin
              gap_left <= 0;
            end else if (roll_tx < 85) begin
              gap_left <= $urandom_range(1, 3);
            end else if (roll_tx < 97) begin
              gap_left <= $urandom_range(4, 12);
            end else begin
              gap_left <= $urandom_range(20, 60);
            end
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor. Each result transfer is checked field by field against the oldest
  // prediction. The ready line stalls at random, with calm stretches in between, and stays
  // low for as long as the long hold-off below asks.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      calm_rx    <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tally_queue.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: tdata=%h tuser=%b",
                                    m_tdata, m_tuser));
        end else begin
          oldest = tally_queue.pop_front();
          if (m_tdata[bdc_pkg::CNT_W-1:0] !== oldest.business_days) begin
            report_mismatch($sformatf("result %0d business_days got %0d want %0d",
                                      results_checked, m_tdata[bdc_pkg::CNT_W-1:0],
                                      oldest.business_days));
          end
          if (m_tdata[bdc_pkg::CNT_W +: bdc_pkg::WD_W] !== oldest.start_weekday) begin
            report_mismatch($sformatf("result %0d start_weekday got %0d want %0d",
                                      results_checked, m_tdata[bdc_pkg::CNT_W +: bdc_pkg::WD_W],
                                      oldest.start_weekday));
          end
          if (m_tdata[bdc_pkg::CNT_W + bdc_pkg::WD_W +: bdc_pkg::WD_W] !== oldest.end_weekday)
          begin
            report_mismatch($sformatf("result %0d end_weekday got %0d want %0d",
                                      results_checked,
                                      m_tdata[bdc_pkg::CNT_W + bdc_pkg::WD_W +: bdc_pkg::WD_W],
                                      oldest.end_weekday));
          end
          if (m_tuser !== oldest.date_invalid) begin
            report_mismatch($sformatf("result %0d date_invalid got %b want %b",
                                      results_checked, m_tuser, oldest.date_invalid));
          end
          if (oldest.date_invalid) begin
            invalid_seen++;
          end
          results_checked++;
        end
      end

      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        if (calm_rx != 0) begin
          calm_rx <= calm_rx - 1;
        end else begin
          roll_rx = $urandom_range(0, 999);
          if (roll_rx < 2) begin
            calm_rx <= 400;
          end else if (roll_rx < 150) begin
            stall_left <= $urandom_range(1, 3);
          end else if (roll_rx < 190) begin
            stall_left <= $urandom_range(4, 15);
          end else if (roll_rx < 193) begin
            stall_left <= $urandom_range(30, 90);
          end
        end
      end
    end
  end

  // Once the run is well under way, the receiver refuses results for a long stretch. The
  // block finishes its request, holds the result and closes its input while the driver
  // keeps offering the next one.
  initial begin
    wait (results_checked >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------------------
  initial begin
    date_pair_t  q;
    cal_date_t   a, b;
    int unsigned i, sel, span;

    // Directed part: field extremes, leap rules, weekday edges and every kind of bad date.
    date_pair_queue.push_back(date_pair(1, 1, 1, 8, 1, 1));          // first possible week
    date_pair_queue.push_back(date_pair(1, 12, 9999, 31, 12, 9999)); // last possible month
    date_pair_queue.push_back(date_pair(15, 3, 2024, 15, 3, 2024));  // start equals end
    date_pair_queue.push_back(date_pair(31, 12, 9999, 1, 1, 1));     // start far after end
    date_pair_queue.push_back(date_pair(28, 2, 2024, 2, 3, 2024));   // across a leap day
    date_pair_queue.push_back(date_pair(28, 2, 1900, 1, 3, 1900));   // century, not leap
    date_pair_queue.push_back(date_pair(27, 2, 2000, 2, 3, 2000));   // every 400 years, leap
    date_pair_queue.push_back(date_pair(29, 2, 2400, 5, 3, 2400));   // leap day as start
    date_pair_queue.push_back(date_pair(25, 12, 2023, 5, 1, 2024));  // across new year
    date_pair_queue.push_back(date_pair(15, 3, 2024, 16, 3, 2024));  // one Friday
    date_pair_queue.push_back(date_pair(16, 3, 2024, 17, 3, 2024));  // one Saturday
    date_pair_queue.push_back(date_pair(17, 3, 2024, 18, 3, 2024));  // one Sunday
    date_pair_queue.push_back(date_pair(14, 3, 2024, 15, 3, 2024));  // one Thursday
    date_pair_queue.push_back(date_pair(29, 2, 2023, 10, 3, 2023));  // leap day, common year
    date_pair_queue.push_back(date_pair(29, 2, 1900, 1, 3, 1900));   // leap day, century
    date_pair_queue.push_back(date_pair(0, 5, 2020, 1, 6, 2020));    // day zero
    date_pair_queue.push_back(date_pair(1, 1, 2020, 31, 4, 2020));   // 31st of a short month
    date_pair_queue.push_back(date_pair(1, 0, 2020, 1, 1, 2020));    // month zero
    date_pair_queue.push_back(date_pair(1, 1, 2020, 1, 13, 2020));   // month thirteen
    date_pair_queue.push_back(date_pair(1, 1, 0, 1, 1, 1));          // year zero
    date_pair_queue.push_back(date_pair(1, 1, 9999, 1, 1, 10000));   // year past the range
    date_pair_queue.push_back(date_pair(31, 15, 16383, 31, 15, 16383)); // all ones
    date_pair_queue.push_back(date_pair(0, 0, 0, 0, 0, 0));          // all zeros
    date_pair_queue.push_back(date_pair(1, 1, 1, 0, 12, 9999));      // bad end, no walk
    date_pair_queue.push_back(date_pair(1, 1, 2020, 1, 1, 2023));    // a few years
    date_pair_queue.push_back(date_pair(1, 1, 1900, 1, 1, 3000));    // one long walk

    // Random part. Most requests are valid pairs a short walk apart; the rest run backward,
    // carry one broken date, or are raw bit patterns.
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      sel = $urandom_range(0, 99);
      a   = rand_date();
      if (sel < 62) begin
        case ($urandom_range(0, 19))
          0:       span = 0;
          1, 2:    span = $urandom_range(41, MAX_RANDOM_WALK);
          3, 4, 5: span = $urandom_range(8, 40);
          default: span = $urandom_range(1, 7);
        endcase
        q.start_date = a;
        q.end_date   = date_after(a, span);
      end else if (sel < 72) begin
        b = $urandom_range(0, 1) ? date_after(a, $urandom_range(1, MAX_RANDOM_WALK))
                                 : rand_date();
        q.start_date = b;
        q.end_date   = a;
      end else if (sel < 82) begin
        q.start_date = a;
        q.end_date   = date_after(a, $urandom_range(1, 60));
        if ($urandom_range(0, 1)) begin
          q.start_date = corrupt_date(q.start_date);
        end else begin
          q.end_date = corrupt_date(q.end_date);
        end
      end else begin
        q.start_date = raw_date();
        q.end_date   = raw_date();
      end
      // Keep the walk short: a valid pair that lies far apart forward is sent the other way.
      if (date_ok(q.start_date) && date_ok(q.end_date) &&
          (day_serial(q.end_date) > day_serial(q.start_date) + MAX_RANDOM_WALK)) begin
        b            = q.start_date;
        q.start_date = q.end_date;
        q.end_date   = b;
      end
      date_pair_queue.push_back(q);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Checked between edges so that nothing from the same edge is half done.
    while ((date_pair_queue.size() != 0) || s_tvalid || (tally_queue.size() != 0)) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tally_queue.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", tally_queue.size()));
    end

    $display("Checked %0d results for %0d date pairs, %0d of them with a bad date.",
             results_checked, requests_sent, invalid_seen);
    $display("Longest walk %0d days; the receiver refused results once for %0d cycles.",
             longest_walk, HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, long walks and stalls included.
  initial begin
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bdc_pkg.sv
rtl/core/bdc_cdiv.sv
rtl/core/bdc_datapath.sv
rtl/core/bdc_ctrl.sv
rtl/core/business_day_counter.sv
rtl/core/bdc_checker.sv
sim/tb_business_day_counter.sv
